// ===== src/sldf_pkg.sv =====
`timescale 1ns / 1ps

package sldf_pkg;

  localparam logic [7:0] SYNC_LO = 8'hEB;
  localparam logic [7:0] SYNC_HI = 8'h90;

  localparam logic [7:0] FTYPE_FILE_LO = 8'h91;
  localparam logic [7:0] FTYPE_FILE_HI = 8'h9E;
  localparam logic [7:0] FTYPE_SHORT   = 8'h61;

  localparam logic [7:0] SUB_NONE_A   = 8'hF1;
  localparam logic [7:0] SUB_NONE_B   = 8'hF6;
  localparam logic [7:0] SUB_FILE_LEN = 8'hF2;
  localparam logic [7:0] SUB_FILE_NUM = 8'hF5;
  localparam logic [7:0] SUB_PAYLOAD  = 8'hF7;

  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // result kinds
  localparam logic [3:0] KIND_FTYPE    = 4'd0;
  localparam logic [3:0] KIND_SUBTYPE  = 4'd1;
  localparam logic [3:0] KIND_FILE_LEN = 4'd2;
  localparam logic [3:0] KIND_MD5      = 4'd3;
  localparam logic [3:0] KIND_NAME     = 4'd4;
  localparam logic [3:0] KIND_FILE_NUM = 4'd5;
  localparam logic [3:0] KIND_PAYLOAD  = 4'd6;
  localparam logic [3:0] KIND_SHORT    = 4'd7;
  localparam logic [3:0] KIND_END      = 4'd8;

  // end status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SYNC  = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_TOO_SHORT = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [5:0]  field_offset;
    logic [1:0]  status;
    logic        last_of_run;
  } result_t;

endpackage

// ===== src/sync_length_frame_deframer.sv =====
`timescale 1ns / 1ps

// Deframer for sync/length frames: EB 90, 16-bit little-endian length, frame
// type, subtype, body. One byte per slave transaction, s_tlast on the final
// byte of a frame. Each byte is decoded in the cycle it is accepted and its
// results (zero, one or two) land in a two-entry output buffer. A byte that
// yields one result, or none, is taken every cycle while the master side
// keeps up; a byte that yields two (a field plus the end result on the last
// byte) holds the slave side while the buffer drains, so throughput is one
// byte per cycle while the master side keeps up, with a stall at each frame end that
// also carries a field. The end result carries the status and the F7 payload
// count; consumers should drop the frame's fields when status is not ok.
// Fields are emitted even on bad sync, and 32-bit words cut short by the end
// of frame are never emitted.
module sync_length_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // slave side: one frame byte per transaction
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // frame_last
  // master side: one decoded result per transaction
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] value, [37:32] field_offset, [39:38] status
  output logic [3:0]  m_tuser,   // [3:0] kind
  output logic        m_tlast    // last_of_run
);
  import sldf_pkg::*;

  // frame state
  logic [COUNT_W-1:0] byte_count;
  logic [15:0]        declared_length;
  logic [7:0]         frame_kind;
  logic [7:0]         sub_kind;
  logic [31:0]        word_accumulator;
  logic               sync_error;
  logic [15:0]        payload_count;

  // output buffer, entry 0 is the head
  result_t    q [2];
  result_t    q_next [2];
  logic [1:0] count;
  logic [1:0] count_next;

  logic pop;
  logic accept;

  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  // Accepting is only allowed when the buffer will be empty after this edge,
  // so both result slots are free for the new byte.
  assign s_tready = (count == 2'd0) || ((count == 2'd1) && m_tready);
  assign accept   = s_tvalid && s_tready;

  assign m_tdata = {q[0].status, q[0].field_offset, q[0].value};
  assign m_tuser = q[0].kind;
  assign m_tlast = q[0].last_of_run;

  // ---------------- per-byte decode ----------------
  logic [COUNT_W-1:0] pos;
  logic [7:0]         b;
  logic               in_file_range;
  logic               word_sub;
  logic [31:0]        wacc_shift;

  logic               fld_valid;
  result_t            fld;
  result_t            end_res;

  logic [COUNT_W-1:0] count_inc;
  logic               sync_error_next;
  logic [15:0]        declared_length_next;
  logic [7:0]         frame_kind_next;
  logic [7:0]         sub_kind_next;
  logic [31:0]        word_accumulator_next;
  logic [15:0]        payload_count_next;

  assign pos           = byte_count;
  assign b             = s_tdata;
  assign in_file_range = (frame_kind >= FTYPE_FILE_LO) && (frame_kind <= FTYPE_FILE_HI);
  assign word_sub      = (sub_kind == SUB_FILE_LEN) || (sub_kind == SUB_FILE_NUM) ||
                         (sub_kind == SUB_PAYLOAD);
  assign wacc_shift    = {b, word_accumulator[31:8]};
  assign count_inc     = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : byte_count;

  always_comb begin
    fld_valid             = 1'b0;
    fld                   = '0;
    sync_error_next       = sync_error;
    declared_length_next  = declared_length;
    frame_kind_next       = frame_kind;
    sub_kind_next         = sub_kind;
    word_accumulator_next = word_accumulator;
    payload_count_next    = payload_count;

    if (pos == COUNT_W'(0)) begin
      if (b != SYNC_LO) sync_error_next = 1'b1;
    end else if (pos == COUNT_W'(1)) begin
      if (b != SYNC_HI) sync_error_next = 1'b1;
    end else if (pos == COUNT_W'(2)) begin
      declared_length_next = {8'd0, b};
    end else if (pos == COUNT_W'(3)) begin
      declared_length_next = {b, declared_length[7:0]};
    end else if (pos == COUNT_W'(4)) begin
      frame_kind_next = b;
      fld_valid       = 1'b1;
      fld.kind        = KIND_FTYPE;
      fld.value       = {24'd0, b};
    end else if (pos == COUNT_W'(5)) begin
      sub_kind_next = b;
      fld_valid     = 1'b1;
      fld.kind      = KIND_SUBTYPE;
      fld.value     = {24'd0, b};
    end else if (in_file_range) begin
      if (word_sub && (pos <= COUNT_W'(9))) begin
        word_accumulator_next = wacc_shift;
        if (pos == COUNT_W'(9)) begin
          fld_valid = 1'b1;
          fld.kind  = (sub_kind == SUB_FILE_LEN) ? KIND_FILE_LEN : KIND_FILE_NUM;
          fld.value = wacc_shift;
        end
      end else if (sub_kind == SUB_FILE_LEN) begin
        if ((pos >= COUNT_W'(10)) && (pos < COUNT_W'(26))) begin
          fld_valid        = 1'b1;
          fld.kind         = KIND_MD5;
          fld.value        = {24'd0, b};
          fld.field_offset = pos[5:0] - 6'd10;
        end else if ((pos >= COUNT_W'(26)) && (pos < COUNT_W'(51))) begin
          fld_valid        = 1'b1;
          fld.kind         = KIND_NAME;
          fld.value        = {24'd0, b};
          fld.field_offset = pos[5:0] - 6'd26;
        end
      end else if (sub_kind == SUB_PAYLOAD) begin
        if (payload_count != 16'hFFFF) payload_count_next = payload_count + 1'b1;
        fld_valid = 1'b1;
        fld.kind  = KIND_PAYLOAD;
        fld.value = {24'd0, b};
      end
    end else if (frame_kind == FTYPE_SHORT) begin
      if (pos == COUNT_W'(6)) begin
        fld_valid = 1'b1;
        fld.kind  = KIND_SHORT;
        fld.value = {24'd0, b};
      end
    end
  end

  // End result, built from the state as it stands after this byte.
  always_comb begin
    end_res             = '0;
    end_res.kind        = KIND_END;
    end_res.value       = {16'd0, payload_count_next};
    end_res.last_of_run = 1'b1;
    if (count_inc < COUNT_W'(4)) begin
      end_res.status = ST_TOO_SHORT;
    end else if (sync_error_next) begin
      end_res.status = ST_BAD_SYNC;
    end else if ({1'b0, declared_length_next} != (count_inc - COUNT_W'(4))) begin
      end_res.status = ST_BAD_LEN;
    end else begin
      end_res.status = ST_OK;
    end
  end

  // ---------------- output buffer ----------------
  always_comb begin
    q_next[0]  = q[0];
    q_next[1]  = q[1];
    count_next = count;
    if (pop) begin
      q_next[0]  = q[1];
      count_next = count - 1'b1;
    end
    if (accept) begin
      // buffer is empty after the pop whenever a byte is accepted
      if (fld_valid) begin
        q_next[0]             = fld;
        q_next[0].last_of_run = !s_tlast;
        q_next[1]             = end_res;
        count_next            = s_tlast ? 2'd2 : 2'd1;
      end else if (s_tlast) begin
        q_next[0]  = end_res;
        count_next = 2'd1;
      end else begin
        count_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count            <= 2'd0;
      byte_count       <= '0;
      declared_length  <= '0;
      frame_kind       <= '0;
      sub_kind         <= '0;
      word_accumulator <= '0;
      sync_error       <= 1'b0;
      payload_count    <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        if (s_tlast) begin
          // frame done: everything back to zero
          byte_count       <= '0;
          declared_length  <= '0;
          frame_kind       <= '0;
          sub_kind         <= '0;
          word_accumulator <= '0;
          sync_error       <= 1'b0;
          payload_count    <= '0;
        end else begin
          byte_count       <= count_inc;
          declared_length  <= declared_length_next;
          frame_kind       <= frame_kind_next;
          sub_kind         <= sub_kind_next;
          word_accumulator <= word_accumulator_next;
          sync_error       <= sync_error_next;
          payload_count    <= payload_count_next;
        end
      end
    end
  end

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("output buffer count out of range");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (byte_count == '0) && (payload_count == '0) && !sync_error)
    else $error("frame state not cleared after last byte");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_END)) |-> m_tlast)
    else $error("end result without last_of_run");

  a_status_end_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_END)) |-> (m_tdata[39:38] == ST_OK))
    else $error("status set on a non-end result");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !s_tready)
    else $error("byte accepted with full output buffer");

endmodule

// ===== verif/sync_length_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

// Frame deframer bench: bytes go in on the slave stream, one per transaction,
// and every decoded field plus the end-of-frame status comes back on the
// master stream. A byte-level decoder in this file tracks the frame state and
// queues the results each accepted byte should produce; the monitor pops them
// in order as master transactions complete.
module sync_length_frame_deframer_tb;
  import sldf_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 1500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // [31:0] value, [37:32] field_offset, [39:38] status
  logic [3:0]  m_tuser;   // [3:0] kind
  logic        m_tlast;   // last_of_run

  sync_length_frame_deframer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder state for the frame in flight
  logic [16:0] fr_count    = '0;
  logic [15:0] fr_len      = '0;
  logic [7:0]  fr_type     = '0;
  logic [7:0]  fr_sub      = '0;
  logic [31:0] fr_word     = '0;
  logic        fr_sync_bad = 1'b0;
  logic [15:0] fr_payload  = '0;

  result_t pending_results[$];
  int      err_count   = 0;
  int      stall_count = 0;
  bit      no_idle     = 1'b0;   // set for stretches where neither side backs off
  result_t got_r, want_r;

  function automatic result_t decoded(input logic [3:0] kind, input logic [31:0] value,
                                      input logic [5:0] offset, input logic [1:0] status);
    result_t r;
    r.kind         = kind;
    r.value        = value;
    r.field_offset = offset;
    r.status       = status;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Append one result to the tail of the scoreboard queue
  function automatic void queue_result(input result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Queue what one byte of the frame decodes to; zero, one or two results.
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [16:0] pos;
    logic [1:0]  st;
    int          depth_in;
    depth_in = pending_results.size();
    pos      = fr_count;
    if (pos == 0) begin
      if (b != SYNC_LO) fr_sync_bad = 1'b1;
    end else if (pos == 1) begin
      if (b != SYNC_HI) fr_sync_bad = 1'b1;
    end else if (pos == 2) begin
      fr_len = {8'h00, b};
    end else if (pos == 3) begin
      fr_len[15:8] = b;
    end else if (pos == 4) begin
      fr_type = b;
      queue_result(decoded(KIND_FTYPE, {24'h0, b}, '0, ST_OK));
    end else if (pos == 5) begin
      fr_sub = b;
      queue_result(decoded(KIND_SUBTYPE, {24'h0, b}, '0, ST_OK));
    end else if (fr_type >= FTYPE_FILE_LO && fr_type <= FTYPE_FILE_HI) begin
      if ((fr_sub == SUB_FILE_LEN || fr_sub == SUB_FILE_NUM || fr_sub == SUB_PAYLOAD) &&
          pos <= 9) begin
        // little-endian word: newest byte shifts in at the top
        fr_word = {b, fr_word[31:8]};
        if (pos == 9)
          queue_result(decoded(fr_sub == SUB_FILE_LEN ? KIND_FILE_LEN : KIND_FILE_NUM,
                               fr_word, '0, ST_OK));
      end else if (fr_sub == SUB_FILE_LEN) begin
        if (pos >= 10 && pos < 26)
          queue_result(decoded(KIND_MD5, {24'h0, b}, 6'(pos - 10), ST_OK));
        else if (pos >= 26 && pos < 51)
          queue_result(decoded(KIND_NAME, {24'h0, b}, 6'(pos - 26), ST_OK));
      end else if (fr_sub == SUB_PAYLOAD) begin
        if (fr_payload != 16'hFFFF) fr_payload++;
        queue_result(decoded(KIND_PAYLOAD, {24'h0, b}, '0, ST_OK));
      end
    end else if (fr_type == FTYPE_SHORT) begin
      if (pos == 6)
        queue_result(decoded(KIND_SHORT, {24'h0, b}, '0, ST_OK));
    end

    if (fr_count != COUNT_MAX) fr_count++;

    if (last) begin
      // too short beats bad sync beats bad length; length compared on the full count
      if (fr_count < 17'd4)
        st = ST_TOO_SHORT;
      else if (fr_sync_bad)
        st = ST_BAD_SYNC;
      else if ({1'b0, fr_len} != fr_count - 17'd4)
        st = ST_BAD_LEN;
      else
        st = ST_OK;
      queue_result(decoded(KIND_END, {16'h0, fr_payload}, '0, st));
      fr_count    = '0;
      fr_len      = '0;
      fr_type     = '0;
      fr_sub      = '0;
      fr_word     = '0;
      fr_sync_bad = 1'b0;
      fr_payload  = '0;
    end

    if (pending_results.size() > depth_in)
      pending_results[pending_results.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic bit take_gap();
    return !no_idle && ($urandom_range(0, 99) < 34);
  endfunction

  task automatic report_error(input string msg);
    if (err_count < 10) $display("ERROR: %s", msg);
    err_count++;
  endtask

  // Entered and left at a falling edge. Valid gets exactly one update per step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (take_gap()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    predict_byte(b, last);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_q_t q);
    for (int i = 0; i < q.size(); i++)
      send_byte(q[i], i == q.size() - 1);
  endtask

  // Header plus random body; length field is the total size less the four sync and length bytes.
  function automatic byte_q_t build_frame(input int len, input logic [7:0] ftype,
                                          input logic [7:0] sub);
    byte_q_t     q;
    logic [15:0] dlen;
    dlen = 16'(len - 4);
    q = {SYNC_LO, SYNC_HI, dlen[7:0], dlen[15:8], ftype, sub};
    while (q.size() < len) q = {q, 8'($urandom)};
    while (q.size() > len) void'(q.pop_back());
    return q;
  endfunction

  // Receiver side: random back-pressure, sampled at the next rising edge
  always @(negedge clk) m_tready <= !take_gap();

  // Monitor: each master transaction against the oldest queued result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_r.kind         = m_tuser;
      got_r.value        = m_tdata[31:0];
      got_r.field_offset = m_tdata[37:32];
      got_r.status       = m_tdata[39:38];
      got_r.last_of_run  = m_tlast;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result kind=%0d value=%h off=%0d st=%0d last=%b",
                               got_r.kind, got_r.value, got_r.field_offset,
                               got_r.status, got_r.last_of_run));
      end else begin
        want_r = pending_results.pop_front();
        if (got_r !== want_r)
          report_error($sformatf({"mismatch: exp kind=%0d value=%h off=%0d st=%0d last=%b",
                                  " / got kind=%0d value=%h off=%0d st=%0d last=%b"},
                                 want_r.kind, want_r.value, want_r.field_offset,
                                 want_r.status, want_r.last_of_run,
                                 got_r.kind, got_r.value, got_r.field_offset,
                                 got_r.status, got_r.last_of_run));
      end
    end
  end

  // Watchdog: the run is hung if no transaction happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("sync_length_frame_deframer_tb NOT OK");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Frames of 1 to 4 bytes: too short wins even over a bad sync byte
  task automatic test_short_frames();
    byte_q_t q;
    q = {8'hEB};
    send_frame(q);
    q = {8'h00, SYNC_HI};
    send_frame(q);
    q = {SYNC_LO, SYNC_HI, 8'h00};
    send_frame(q);
    q = {SYNC_LO, SYNC_HI, 8'h00, 8'h00};   // empty body, length 0 -> ok
    send_frame(q);
  endtask

  // Short data type, file number with bad sync, max declared length
  task automatic test_frame_types();
    byte_q_t q;
    q = {SYNC_LO, SYNC_HI, 8'h03, 8'h00, FTYPE_SHORT, 8'hFF, 8'h5A};
    send_frame(q);
    q = {8'h00, SYNC_HI, 8'h06, 8'h00, FTYPE_FILE_HI, SUB_FILE_NUM,
         8'h01, 8'h02, 8'h03, 8'h04};
    send_frame(q);
    q = {SYNC_LO, SYNC_HI, 8'hFF, 8'hFF, FTYPE_FILE_LO, SUB_NONE_A};
    send_frame(q);
  endtask

  // Mostly well-formed frames with random content, plus broken ones
  task automatic test_random_frames();
    byte_q_t    q;
    int         total;
    int         n_frames;
    int         len;
    logic [7:0] ft;
    logic [7:0] sub;
    total    = 0;
    n_frames = 0;
    while (total < RANDOM_BYTES) begin
      no_idle = (n_frames >= 20 && n_frames < 30);
      if (n_frames == 12) begin
        // hold the sender until the decoder has fully drained
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: ft = 8'($urandom_range(int'(FTYPE_FILE_LO), int'(FTYPE_FILE_HI)));
        5, 6:          ft = FTYPE_SHORT;
        7:             ft = $urandom_range(0, 1) ? FTYPE_FILE_LO - 8'd1 : FTYPE_FILE_HI + 8'd1;
        default:       ft = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       sub = SUB_NONE_A;
        1:       sub = SUB_NONE_B;
        2:       sub = SUB_FILE_LEN;
        3:       sub = SUB_FILE_NUM;
        4:       sub = SUB_PAYLOAD;
        default: sub = 8'($urandom);
      endcase
      if (sub == SUB_FILE_LEN)
        len = ($urandom_range(0, 9) < 7) ? 51 : $urandom_range(6, 60);
      else if (sub == SUB_FILE_NUM)
        len = $urandom_range(0, 1) ? 10 : $urandom_range(6, 14);
      else if (sub == SUB_PAYLOAD)
        len = $urandom_range(6, 40);
      else
        len = $urandom_range(6, 12);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 8);
      q = build_frame(len, ft, sub);
      // broken sync bytes and length fields
      if ($urandom_range(0, 9) == 0) q[0] = q[0] ^ 8'($urandom_range(1, 255));
      if (len > 1 && $urandom_range(0, 9) == 0) q[1] = q[1] ^ 8'($urandom_range(1, 255));
      if (len > 3 && $urandom_range(0, 6) == 0) begin
        q[2] = 8'($urandom);
        q[3] = 8'($urandom);
      end
      send_frame(q);
      total += len;
      n_frames++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_short_frames();
    test_frame_types();
    test_random_frames();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("sync_length_frame_deframer_tb OK");
    else
      $display("sync_length_frame_deframer_tb NOT OK");
    $finish;
  end

endmodule
